/* rtl/dcm_pkg.sv */
// package with payload types, widths and state codes of the duty cycle meter
`default_nettype none

package dcm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 24;
    localparam int FRAC_W   = 16;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } sample_item_t;

    typedef struct packed {
        logic [FRAC_W-1:0]  duty_fraction;
        logic [COUNT_W-1:0] high_samples;
        logic [COUNT_W-1:0] period_samples;
        logic               overflow;
    } result_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] high_len;
        logic [COUNT_W-1:0] period_len;
        logic               overflow;
    } div_job_t;

    typedef enum logic [1:0] {
        PH_SEEK_FIRST = 2'd0,
        PH_SEEK_FALL  = 2'd1,
        PH_SEEK_RISE  = 2'd2
    } phase_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DIV  = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/duty_cycle_meter_top.sv */
// top level of the duty cycle meter
//
// input channel: push with sample_item (sample, last_sample); a request is taken
// at a clock edge with push high and full low. one sample per cycle is taken
// as long as the job queue has room.
// result channel: result holds the oldest result while empty is low; it is
// taken at a clock edge with pop high and empty low.
// a result is made at every rise after a rise and a fall were found; the
// period is at least two samples, so results come at most every other sample.
// each result runs through a bit-serial divider that forms FRAC_W quotient bits;
// the divider takes a new job only after its last result is in the output
// register, so short bursts of periods wait in the job queue (JOB_DEPTH
// entries), and full rises when it fills.
// when the receiver stalls the finished result waits in the output register,
// the divider holds its answer and the job queue fills up behind it.
// last_sample ends a stream: phase, counters and flag clear after that sample.
// reset clears the phase, counters, queue and output valid flag; no clearing pass
`default_nettype none

module duty_cycle_meter_top
    import dcm_pkg::*;
#(
    parameter int JOB_DEPTH = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire sample_item_t sample_item,
    output logic              empty,
    input  wire logic         pop,
    output result_item_t      result
);

    logic     accept;
    logic     job_push;
    div_job_t job_in;
    div_job_t job_out;
    logic     job_pop;
    logic     job_empty;

    assign accept = push && !full;

    dcm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (sample_item),
        .job_push (job_push),
        .job      (job_in)
    );

    dcm_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (full),
        .empty   (job_empty)
    );

    dcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

/* rtl/dcm_front.sv */
// front end: edge detection, period and high length counters, job issue
`default_nettype none

module dcm_front
    import dcm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire sample_item_t item,
    output logic              job_push,
    output div_job_t          job
);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    phase_t                      phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0]  prev_reg, prev_next;
    logic                        prev_valid_reg, prev_valid_next;
    logic [COUNT_W-1:0]          cnt_reg, cnt_next;
    logic [COUNT_W-1:0]          high_reg, high_next;
    logic                        sat_reg, sat_next;

    logic rise, fall;

    assign rise = item.sample > prev_reg;
    assign fall = item.sample < prev_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (prev_valid_reg)
            begin
                unique case (phase_reg)
                    PH_SEEK_FALL:
                    begin
                        if (fall)
                            phase_next = PH_SEEK_RISE;
                    end
                    PH_SEEK_RISE:
                    begin
                        if (rise)
                            phase_next = PH_SEEK_FALL;
                    end
                    default:
                    begin
                        phase_next = rise ? PH_SEEK_FALL : PH_SEEK_FIRST;
                    end
                endcase
            end
            if (item.last_sample)
                phase_next = PH_SEEK_FIRST;
        end
    end

    // counters, job issue
    always_comb
    begin
        logic [COUNT_W-1:0] cnt_base;
        logic               sat_base;
        cnt_base        = cnt_reg;
        sat_base        = sat_reg;
        high_next       = high_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        job_push        = 1'b0;
        job.high_len    = high_reg;
        job.period_len  = cnt_reg;
        job.overflow    = sat_reg;
        if (accept && prev_valid_reg)
        begin
            unique case (phase_reg)
                PH_SEEK_FALL:
                begin
                    if (fall)
                        high_next = cnt_reg;
                end
                PH_SEEK_RISE:
                begin
                    if (rise)
                    begin
                        job_push = 1'b1;
                        cnt_base = '0;
                        sat_base = 1'b0;
                    end
                end
                default:
                begin
                    if (rise)
                    begin
                        cnt_base  = '0;
                        sat_base  = 1'b0;
                        high_next = '0;
                    end
                end
            endcase
        end
        cnt_next = cnt_base;
        sat_next = sat_base;
        if (accept && prev_valid_reg &&
            (phase_next == PH_SEEK_FALL || phase_next == PH_SEEK_RISE || item.last_sample))
        begin
            if (cnt_base == COUNT_MAX)
                sat_next = 1'b1;
            else
                cnt_next = cnt_base + COUNT_W'(1);
        end
        if (accept)
        begin
            prev_next       = item.sample;
            prev_valid_next = 1'b1;
            if (item.last_sample)
            begin
                prev_next       = '0;
                prev_valid_next = 1'b0;
                cnt_next        = '0;
                high_next       = '0;
                sat_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEEK_FIRST;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            high_reg       <= '0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            cnt_reg        <= cnt_next;
            high_reg       <= high_next;
            sat_reg        <= sat_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dcm_fifo.sv */
// short job queue between front end and divider
`default_nettype none

module dcm_fifo
    import dcm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire div_job_t wr_data,
    input  wire logic     rd_en,
    output div_job_t      rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    div_job_t          slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dcm_back.sv */
// back end: bit-serial duty divider and result register
`default_nettype none

module dcm_back
    import dcm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_avail,
    input  wire div_job_t job,
    output logic          job_pop,
    output result_item_t  result,
    output logic          empty,
    input  wire logic     pop
);

    localparam int STEP_W = $clog2(FRAC_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_W);

    back_state_t         state_reg, state_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  div_reg, div_next;
    logic [FRAC_W-1:0]   quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  high_reg, high_next;
    logic                ovf_reg, ovf_next;
    logic                res_valid_reg, res_valid_next;
    result_item_t        res_reg, res_next;

    logic                slot_free;
    logic                done;
    logic [COUNT_W:0]    shifted;
    logic [COUNT_W:0]    diff;
    logic                ge;

    assign slot_free = !res_valid_reg || pop;
    assign done      = step_reg == STEP_LAST;
    assign shifted   = {rem_reg, 1'b0};
    assign diff      = shifted - {1'b0, div_reg};
    assign ge        = shifted >= {1'b0, div_reg};
    assign empty     = !res_valid_reg;
    assign result    = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_avail)
                    state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (done && slot_free)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rem_next       = rem_reg;
        div_next       = div_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        high_next      = high_reg;
        ovf_next       = ovf_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        job_pop        = 1'b0;
        if (pop && res_valid_reg)
            res_valid_next = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop   = 1'b1;
                    rem_next  = job.high_len;
                    div_next  = job.period_len;
                    high_next = job.high_len;
                    ovf_next  = job.overflow;
                    quot_next = '0;
                    step_next = '0;
                    // zero period gives zero, a full period saturates
                    if (job.period_len == '0)
                        step_next = STEP_LAST;
                    else if (job.high_len >= job.period_len)
                    begin
                        quot_next = '1;
                        step_next = STEP_LAST;
                    end
                end
            end
            BK_DIV:
            begin
                if (!done)
                begin
                    rem_next  = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
                    quot_next = {quot_reg[FRAC_W-2:0], ge};
                    step_next = step_reg + STEP_W'(1);
                end
                else if (slot_free)
                begin
                    res_next.duty_fraction  = quot_reg;
                    res_next.high_samples   = high_reg;
                    res_next.period_samples = div_reg;
                    res_next.overflow       = ovf_reg;
                    res_valid_next          = 1'b1;
                end
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
        high_reg <= high_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

/* bench/duty_cycle_checker.sv */
// checker for the duty cycle meter: predicts results from accepted samples and compares
`timescale 1ns / 1ps

module duty_cycle_checker
    import dcm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic         full,
    input  sample_item_t sample_item,
    input  logic         empty,
    input  logic         pop,
    input  result_item_t result,
    output int           errors,
    output int           pending
);

    result_item_t               expected_q[$];
    logic signed [SAMPLE_W-1:0] prev_smp;
    logic                       prev_ok;
    phase_t                     ph;
    logic [COUNT_W-1:0]         run_len;
    logic [COUNT_W-1:0]         hi_len;
    logic                       sat;

    function automatic logic [FRAC_W-1:0] duty_ratio(logic [COUNT_W-1:0] hi,
                                                     logic [COUNT_W-1:0] per);
        logic [COUNT_W+FRAC_W-1:0] q;
        if (per == '0)
            return '0;
        q = {hi, {FRAC_W{1'b0}}} / per;
        if (q > {FRAC_W{1'b1}})
            return '1;
        return q[FRAC_W-1:0];
    endfunction

    task automatic clear_stream();
        prev_smp = '0;
        prev_ok  = 1'b0;
        ph       = PH_SEEK_FIRST;
        run_len  = '0;
        hi_len   = '0;
        sat      = 1'b0;
    endtask

    task automatic take_sample(sample_item_t it);
        result_item_t r;
        logic         rise;
        logic         fall;
        rise = $signed(it.sample) > prev_smp;
        fall = $signed(it.sample) < prev_smp;
        if (prev_ok)
        begin
            case (ph)
                PH_SEEK_FALL:
                begin
                    if (fall)
                    begin
                        hi_len = run_len;
                        ph     = PH_SEEK_RISE;
                    end
                end
                PH_SEEK_RISE:
                begin
                    if (rise)
                    begin
                        r.duty_fraction  = duty_ratio(hi_len, run_len);
                        r.high_samples   = hi_len;
                        r.period_samples = run_len;
                        r.overflow       = sat;
                        expected_q       = {expected_q, r};
                        run_len = '0;
                        sat     = 1'b0;
                        ph      = PH_SEEK_FALL;
                    end
                end
                default:
                begin
                    if (rise)
                    begin
                        run_len = '0;
                        sat     = 1'b0;
                        hi_len  = '0;
                        ph      = PH_SEEK_FALL;
                    end
                    else
                    begin
                        ph = PH_SEEK_FIRST;
                    end
                end
            endcase
            if (ph == PH_SEEK_FALL || ph == PH_SEEK_RISE)
            begin
                if (run_len == '1)
                    sat = 1'b1;
                else
                    run_len = run_len + 1'b1;
            end
        end
        prev_smp = it.sample;
        prev_ok  = 1'b1;
        if (it.last_sample)
            clear_stream();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_item_t exp_r;
        if (!rst_n)
        begin
            clear_stream();
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (push && !full)
                take_sample(sample_item);
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result duty=%h high=%0d period=%0d ovf=%0b",
                                 $realtime, result.duty_fraction, result.high_samples,
                                 result.period_samples, result.overflow);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.duty_fraction !== exp_r.duty_fraction
                        || result.high_samples !== exp_r.high_samples
                        || result.period_samples !== exp_r.period_samples
                        || result.overflow !== exp_r.overflow)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch exp duty=%h high=%0d period=%0d ovf=%0b",
                                      " got duty=%h high=%0d period=%0d ovf=%0b"},
                                     $realtime, exp_r.duty_fraction, exp_r.high_samples,
                                     exp_r.period_samples, exp_r.overflow,
                                     result.duty_fraction, result.high_samples,
                                     result.period_samples, result.overflow);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// testbench top for the duty cycle meter: clock, reset, sample stimulus and verdict
`timescale 1ns / 1ps

module tb_top
    import dcm_pkg::*;
();

    localparam int N_ITEMS  = 1700;
    localparam int RX_HOLD  = 300;
    localparam int WATCHDOG = 5000;

    logic         clk;
    logic         rst_n;
    logic         push;
    logic         full;
    sample_item_t sample_item;
    logic         empty;
    logic         pop;
    result_item_t result;

    int errors;
    int pending;
    int sent;
    int idle_cycles;
    bit tx_calm;
    bit rx_calm;
    bit hold_rx;
    int lvl;

    duty_cycle_meter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    duty_cycle_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_item (sample_item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .errors      (errors),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int idle_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 25);
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    task automatic send(int s, logic lst);
        int gap;
        gap = idle_len(tx_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        sample_item <= {s[SAMPLE_W-1:0], lst};
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic wave_stream(int periods, int step_max, bit end_stream);
        int run;
        for (int p = 0; p < periods; p++)
        begin
            run = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(5, 1);
            for (int k = 0; k < run; k++)
            begin
                lvl = clamp16(lvl + $urandom_range(step_max, 1));
                send(lvl, 1'b0);
                if ($urandom_range(9) == 0)
                    send(lvl, 1'b0);
            end
            run = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(5, 1);
            for (int k = 0; k < run; k++)
            begin
                lvl = clamp16(lvl - $urandom_range(step_max, 1));
                send(lvl, 1'b0);
                if ($urandom_range(9) == 0)
                    send(lvl, 1'b0);
            end
        end
        lvl = clamp16(lvl + $urandom_range(step_max, 1));
        send(lvl, end_stream);
    endtask

    task automatic fill_up();
        hold_rx = 1'b1;
        tx_calm = 1'b1;
        repeat (40)
        begin
            send(0, 1'b0);
            send(1, 1'b0);
        end
        send(0, 1'b1);
        tx_calm = 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic int pick_step();
        case ($urandom_range(3))
            0:       return 3;
            1:       return 200;
            2:       return 5000;
            default: return 40000;
        endcase
    endfunction

    // receiver
    initial
    begin
        int rx_wait;
        rx_wait = 0;
        pop     = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                pop <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
                hold_rx = 1'b0;
                rx_wait = 0;
                pop <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                if (rx_wait == 0)
                    pop <= 1'b1;
            end
            else if (pop && !empty)
            begin
                rx_wait = idle_len(rx_calm);
                if (rx_wait > 0)
                    pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // sender
    initial
    begin
        int r;
        rst_n       = 1'b0;
        push        = 1'b0;
        sample_item = '0;
        sent        = 0;
        idle_cycles = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_rx     = 1'b0;
        lvl         = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone sample, then extremes with level runs
        send(100, 1'b1);
        send(-32768, 1'b0);
        send(32767, 1'b0);
        send(32767, 1'b0);
        send(-32768, 1'b0);
        send(-32768, 1'b0);
        send(32767, 1'b0);
        send(-1, 1'b0);
        send(0, 1'b0);
        send(0, 1'b0);
        send(-1, 1'b0);
        send(1, 1'b1);
        // level only stream, never leaves the first phase
        send(5, 1'b0);
        send(5, 1'b0);
        send(5, 1'b1);
        // shortest period with a result on the final sample
        send(0, 1'b0);
        send(1, 1'b0);
        send(0, 1'b0);
        send(1, 1'b1);
        // falls before any rise
        send(10, 1'b0);
        send(9, 1'b0);
        send(8, 1'b0);
        send(9, 1'b0);
        send(7, 1'b0);
        send(8, 1'b1);

        fill_up();
        drain();

        while (sent < N_ITEMS)
        begin
            r       = $urandom_range(99);
            tx_calm = ($urandom_range(7) == 0);
            rx_calm = ($urandom_range(7) == 0);
            if (r < 72)
                wave_stream($urandom_range(6, 1), pick_step(), $urandom_range(3) != 0);
            else if (r < 87)
            begin
                repeat ($urandom_range(20, 4))
                    send($urandom, $urandom_range(7) == 0);
            end
            else if (r < 93)
            begin
                repeat ($urandom_range(3, 1))
                    send(lvl, 1'b0);
                lvl = clamp16(lvl + $urandom_range(50, 1));
                send(lvl, 1'b0);
                send(lvl, 1'($urandom_range(1)));
            end
            else if (r < 97)
                fill_up();
            else
                drain();
        end

        tx_calm = 1'b0;
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
